/* design/exp_golomb_bit_packer_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Exp-Golomb bit packer
// Same-cycle and next-cycle implication checks; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef EXP_GOLOMB_BIT_PACKER_UNIT_MACROS_SVH
`define EXP_GOLOMB_BIT_PACKER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define EGBP_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egbp: same-cycle check failed");
`define EGBP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egbp: next-cycle check failed");
`else
`define EGBP_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define EGBP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/egbp_pkg.sv */
// ----------------------------------------------------------------------------
// egbp_pkg
// Shared constants and types of the Exp-Golomb bit packer.
// ----------------------------------------------------------------------------
package egbp_pkg;

  localparam int ByteBits  = 8;
  localparam int WordBits  = 16;
  localparam int CodeBits  = WordBits + 1;
  localparam int MaxBytes  = 5;
  localparam int AccBits   = MaxBytes * ByteBits;
  localparam int CntBits   = 3;
  localparam int KBits     = 4;

  typedef enum logic {
    CfgSignedMode = 1'b0,
    CfgKOrder     = 1'b1
  } cfg_idx_e;

  // One coded item, left-aligned, ready for the output buffer
  typedef struct packed {
    logic [AccBits-1:0] bits;
    logic [CntBits-1:0] cnt;
    logic               fin;
  } enc_t;

endpackage

/* design/exp_golomb_bit_packer_unit.sv */
// ----------------------------------------------------------------------------
// exp_golomb_bit_packer_unit
// Exp-Golomb order-k encoder packing codes MSB first into bytes.
// ----------------------------------------------------------------------------
// An accepted value sits in the input register, is coded and merged with the
// pending bits in one pass, and is loaded into the output buffer once that is
// free; its first byte then comes from the output buffer. The output buffer
// sends one byte per cycle while the output is not stalled: a value that
// yields m bytes (0 to 5) holds the buffer until all are sent, and the input
// register takes a new value every cycle as long as each value yields at most
// one byte and the output is not stalled. The worst case, a 33-bit code on top
// of 7 pending bits, yields 5 bytes. Values that complete no byte leave the
// buffer free. Registers are written through a valid/ready port, always ready.
`include "exp_golomb_bit_packer_unit_macros.svh"

module exp_golomb_bit_packer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [egbp_pkg::KBits-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [egbp_pkg::WordBits-1:0] sample_word_i,
  input  logic                          stream_end_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [egbp_pkg::ByteBits-1:0] packed_byte_o,
  output logic                          final_byte_o
);

  logic                          signed_mode_q;
  logic [egbp_pkg::KBits-1:0]    k_order_q;
  logic                          s1_valid_q, s1_valid_d;
  logic [egbp_pkg::WordBits-1:0] s1_word_q;
  logic                          s1_end_q;
  logic                          in_xfer;
  logic                          move;
  logic                          drain_free;
  egbp_pkg::enc_t                enc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q <= 1'b0;
      k_order_q     <= '0;
    end else if (cfg_valid_i) begin
      case (egbp_pkg::cfg_idx_e'(cfg_index_i))
        egbp_pkg::CfgSignedMode: signed_mode_q <= cfg_data_i[0];
        egbp_pkg::CfgKOrder:     k_order_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // hold the input register until the output buffer can take its bytes
  assign move       = s1_valid_q & drain_free;
  assign in_stall_o = s1_valid_q & ~move;
  assign in_xfer    = in_valid_i & ~in_stall_o;
  assign s1_valid_d = in_xfer | (s1_valid_q & ~move);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_word_q <= sample_word_i;
      s1_end_q  <= stream_end_i;
    end
  end

  egbp_encoder u_encoder (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (move),
    .signed_mode_i (signed_mode_q),
    .k_order_i     (k_order_q),
    .sample_word_i (s1_word_q),
    .stream_end_i  (s1_end_q),
    .enc_o         (enc)
  );

  egbp_drain u_drain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (move),
    .enc_i         (enc),
    .out_stall_i   (out_stall_i),
    .free_o        (drain_free),
    .out_valid_o   (out_valid_o),
    .packed_byte_o (packed_byte_o),
    .final_byte_o  (final_byte_o)
  );

  `EGBP_ASSERT_SAME(a_final_has_valid, clk_i, rst_ni, final_byte_o, out_valid_o)
  `EGBP_ASSERT_NEXT(a_end_gives_byte, clk_i, rst_ni, move && s1_end_q, out_valid_o)
  `EGBP_ASSERT_NEXT(a_mid_not_final, clk_i, rst_ni, move && !s1_end_q, !final_byte_o)

endmodule

/* design/egbp_encoder.sv */
// ----------------------------------------------------------------------------
// egbp_encoder
// Codes one value, merges it behind the pending bits and keeps the leftover.
// ----------------------------------------------------------------------------
module egbp_encoder (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 advance_i,
  input  logic                                 signed_mode_i,
  input  logic [egbp_pkg::KBits-1:0]           k_order_i,
  input  logic [egbp_pkg::WordBits-1:0]        sample_word_i,
  input  logic                                 stream_end_i,
  output egbp_pkg::enc_t                       enc_o
);

  logic [egbp_pkg::ByteBits-2:0] pend_q, pend_d;
  logic [egbp_pkg::CntBits-1:0]  pcnt_q, pcnt_d;

  always_comb begin
    logic [egbp_pkg::WordBits-1:0] u;
    logic [egbp_pkg::CodeBits-1:0] e;
    logic [4:0]                    w;
    logic [5:0]                    len;
    logic [5:0]                    total;
    logic [5:0]                    shamt;
    logic [egbp_pkg::AccBits-1:0]  bits;
    logic [egbp_pkg::CntBits-1:0]  nfull;
    logic [egbp_pkg::ByteBits-1:0] nbyte;
    // zigzag: negative v -> -2v-1, else 2v
    u = signed_mode_i
      ? {sample_word_i[egbp_pkg::WordBits-2:0] ^ {(egbp_pkg::WordBits-1){sample_word_i[15]}},
         sample_word_i[egbp_pkg::WordBits-1]}
      : sample_word_i;
    e = {1'b0, u} + (egbp_pkg::CodeBits'(1) << k_order_i);
    w = '0;
    for (int i = 0; i < egbp_pkg::CodeBits; i++) begin
      if (e[i]) w = 5'(i + 1);
    end
    // prefix zeros plus w code bits
    len   = {w, 1'b0} - 6'd1 - {2'b00, k_order_i};
    total = len + {3'b000, pcnt_q};
    shamt = 6'(egbp_pkg::AccBits) - total;
    bits  = {pend_q, 1'b0, {(egbp_pkg::AccBits - egbp_pkg::ByteBits){1'b0}}}
          | ((egbp_pkg::AccBits)'(e) << shamt);
    nfull = total[5:3];
    // byte right after the full ones: leftover bits, zero padded below
    nbyte = '0;
    for (int b = 0; b < egbp_pkg::MaxBytes; b++) begin
      if (nfull == egbp_pkg::CntBits'(b)) begin
        nbyte = bits[egbp_pkg::AccBits-1-b*egbp_pkg::ByteBits -: egbp_pkg::ByteBits];
      end
    end
    enc_o.bits = bits;
    enc_o.cnt  = nfull + {2'b00, stream_end_i & (total[2:0] != 3'd0)};
    enc_o.fin  = stream_end_i;
    pend_d     = stream_end_i ? '0 : nbyte[egbp_pkg::ByteBits-1:1];
    pcnt_d     = stream_end_i ? '0 : total[2:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      pcnt_q <= '0;
    end else if (advance_i) begin
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
    end
  end

endmodule

/* design/egbp_drain.sv */
// ----------------------------------------------------------------------------
// egbp_drain
// Output buffer: holds the bytes of one coded item and sends one per transfer.
// ----------------------------------------------------------------------------
module egbp_drain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          load_i,
  input  egbp_pkg::enc_t                enc_i,
  input  logic                          out_stall_i,
  output logic                          free_o,
  output logic                          out_valid_o,
  output logic [egbp_pkg::ByteBits-1:0] packed_byte_o,
  output logic                          final_byte_o
);

  logic [egbp_pkg::AccBits-1:0] data_q, data_d;
  logic [egbp_pkg::CntBits-1:0] cnt_q, cnt_d;
  logic                         fin_q, fin_d;
  logic                         out_xfer;

  assign out_valid_o   = (cnt_q != '0);
  assign out_xfer      = out_valid_o & ~out_stall_i;
  assign free_o        = (cnt_q == '0) | ((cnt_q == egbp_pkg::CntBits'(1)) & ~out_stall_i);
  assign packed_byte_o = data_q[egbp_pkg::AccBits-1 -: egbp_pkg::ByteBits];
  assign final_byte_o  = fin_q & (cnt_q == egbp_pkg::CntBits'(1));

  always_comb begin
    data_d = data_q;
    cnt_d  = cnt_q;
    fin_d  = fin_q;
    if (load_i) begin
      data_d = enc_i.bits;
      cnt_d  = enc_i.cnt;
      fin_d  = enc_i.fin;
    end else if (out_xfer) begin
      // advance to the next byte
      data_d = data_q << egbp_pkg::ByteBits;
      cnt_d  = cnt_q - egbp_pkg::CntBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      fin_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      fin_q <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

/* tb/egbp_stream_checker.sv */
// ----------------------------------------------------------------------------
// egbp_stream_checker
// Watches the config, sample and byte channels of the Exp-Golomb packer,
// predicts the coded byte stream and compares every byte transfer with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module egbp_stream_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic                          cfg_index_i,
  input  logic [egbp_pkg::KBits-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic [egbp_pkg::WordBits-1:0] sample_word_i,
  input  logic                          stream_end_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [egbp_pkg::ByteBits-1:0] packed_byte_i,
  input  logic                          final_byte_i,
  input  logic                          drain_done_i,
  output int                            byte_backlog_o,
  output int                            fail_count_o
);

  typedef struct packed {
    logic [egbp_pkg::ByteBits-1:0] data;
    logic                          fin;
  } coded_byte_t;

  coded_byte_t                  coded_bytes_q[$];
  logic                         zigzag_on;
  logic [egbp_pkg::KBits-1:0]   k_sel;
  logic [6:0]                   held_bits;
  logic [egbp_pkg::CntBits-1:0] held_cnt;
  int                           fails;
  bit                           leftover_checked;

  assign fail_count_o = fails;

  task automatic report_mismatch(input string what);
    fails++;
    $display("%0t ns  mismatch: %s", $time, what);
  endtask

  // Zigzag: negative v -> -2v-1, non-negative v -> 2v, kept to 16 bits
  function automatic logic [egbp_pkg::WordBits-1:0] code_number(
    input logic [egbp_pkg::WordBits-1:0] word);
    logic [16:0] mag;
    logic [17:0] odd;
    if (!zigzag_on) return word;
    if (word[15]) begin
      mag = 17'h10000 - {1'b0, word};
      odd = {mag, 1'b0} - 18'd1;
      return odd[egbp_pkg::WordBits-1:0];
    end
    return {word[14:0], 1'b0};
  endfunction

  // Code one sample, append its completed bytes, keep the leftover bits
  function automatic void pack_sample(input logic [egbp_pkg::WordBits-1:0] word,
                                      input logic last);
    logic [egbp_pkg::CodeBits-1:0] code;
    logic [63:0]                   acc;
    int unsigned                   width;
    int unsigned                   zeros;
    int unsigned                   n;
    int                            base;
    coded_byte_t                   b;
    code  = {1'b0, code_number(word)} + (17'd1 << k_sel);
    width = 0;
    for (int i = 0; i < egbp_pkg::CodeBits; i++) if (code[i]) width = i + 1;
    zeros = width - 1 - k_sel;
    n     = held_cnt;
    base  = coded_bytes_q.size();
    acc   = 64'(held_bits) & ((64'd1 << n) - 64'd1);
    acc   = (acc << (zeros + width)) | 64'(code);
    n     = n + zeros + width;
    while (n >= egbp_pkg::ByteBits) begin
      b.data = egbp_pkg::ByteBits'(acc >> (n - egbp_pkg::ByteBits));
      b.fin  = 1'b0;
      coded_bytes_q.insert(coded_bytes_q.size(), b);
      n -= egbp_pkg::ByteBits;
    end
    if (last && n > 0) begin
      // pad the partial byte with zeros
      b.data = egbp_pkg::ByteBits'(acc << (egbp_pkg::ByteBits - n));
      b.fin  = 1'b0;
      coded_bytes_q.insert(coded_bytes_q.size(), b);
      n = 0;
    end
    if (last && coded_bytes_q.size() > base) begin
      b = coded_bytes_q[coded_bytes_q.size() - 1];
      b.fin = 1'b1;
      coded_bytes_q[coded_bytes_q.size() - 1] = b;
    end
    held_bits = 7'(acc & ((64'd1 << n) - 64'd1));
    held_cnt  = egbp_pkg::CntBits'(n);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    coded_byte_t want;
    if (!rst_ni) begin
      coded_bytes_q.delete();
      zigzag_on        = 1'b0;
      k_sel            = '0;
      held_bits        = '0;
      held_cnt         = '0;
      fails            = 0;
      leftover_checked = 1'b0;
      byte_backlog_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        if (egbp_pkg::cfg_idx_e'(cfg_index_i) == egbp_pkg::CfgSignedMode)
          zigzag_on = cfg_data_i[0];
        else k_sel = cfg_data_i;
      end
      if (out_valid_i && !out_stall_i) begin
        if (coded_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected byte %02h final %0b",
                                    packed_byte_i, final_byte_i));
        end else begin
          want = coded_bytes_q.pop_front();
          if (packed_byte_i !== want.data)
            report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                      packed_byte_i, want.data));
          if (final_byte_i !== want.fin)
            report_mismatch($sformatf("final_byte %0b, expected %0b on byte %02h",
                                      final_byte_i, want.fin, want.data));
        end
      end
      if (in_valid_i && !in_stall_i) pack_sample(sample_word_i, stream_end_i);
      if (drain_done_i && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (coded_bytes_q.size() != 0)
          report_mismatch($sformatf("%0d bytes never arrived", coded_bytes_q.size()));
      end
      byte_backlog_o <= coded_bytes_q.size();
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives samples and register writes into the Exp-Golomb packer: a directed
// pass over the code extremes, then random phases with random settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  logic                          clk         = 1'b0;
  logic                          rst_n       = 1'b0;
  logic                          cfg_valid   = 1'b0;
  logic                          cfg_ready;
  egbp_pkg::cfg_idx_e            cfg_index   = egbp_pkg::CfgSignedMode;
  logic [egbp_pkg::KBits-1:0]    cfg_data    = '0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall;
  logic [egbp_pkg::WordBits-1:0] sample_word = '0;
  logic                          stream_end  = 1'b0;
  logic                          out_valid;
  logic                          out_stall   = 1'b0;
  logic [egbp_pkg::ByteBits-1:0] packed_byte;
  logic                          final_byte;
  logic                          drain_done  = 1'b0;
  bit                            idle_on     = 1'b1;
  int                            byte_backlog;
  int                            fail_count;

  always #6 clk = ~clk;

  exp_golomb_bit_packer_unit u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .sample_word_i (sample_word),
    .stream_end_i  (stream_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .packed_byte_o (packed_byte),
    .final_byte_o  (final_byte)
  );

  egbp_stream_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_i    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .sample_word_i  (sample_word),
    .stream_end_i   (stream_end),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .packed_byte_i  (packed_byte),
    .final_byte_i   (final_byte),
    .drain_done_i   (drain_done),
    .byte_backlog_o (byte_backlog),
    .fail_count_o   (fail_count)
  );

  always @(posedge clk) out_stall <= idle_on && ($urandom_range(99) < 19);

  task automatic send_sample(input logic [egbp_pkg::WordBits-1:0] word, input logic last);
    while (idle_on && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    sample_word <= word;
    stream_end  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Lower valid and let the pipeline empty, including samples with no byte
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (byte_backlog != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_config(input logic mode, input logic [egbp_pkg::KBits-1:0] k);
    cfg_valid <= 1'b1;
    cfg_index <= egbp_pkg::CfgSignedMode;
    cfg_data  <= {3'b000, mode};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= egbp_pkg::CfgKOrder;
    cfg_data  <= k;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [egbp_pkg::WordBits-1:0] pick_sample();
    case ($urandom_range(6))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
      3:       return 16'($urandom_range(16)) - 16'd8;
      4:       return 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [egbp_pkg::KBits-1:0] k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-bit code padded out; longest codes back to back
    set_config(1'b0, 4'd0);
    send_sample(16'h0000, 1'b1);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_idle();
    // code of exactly one byte ends the stream with no padding
    set_config(1'b0, 4'd1);
    send_sample(16'd14, 1'b1);
    wait_idle();
    set_config(1'b1, 4'd15);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b0);
    wait_idle();
    // change settings with bits still pending
    set_config(1'b1, 4'd0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    wait_idle();
    set_config(1'b0, 4'd15);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h8000, 1'b1);
    wait_idle();

    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(3))
        0:       k = 4'd0;
        1:       k = 4'd15;
        default: k = 4'($urandom_range(15));
      endcase
      set_config(1'($urandom_range(1)), k);
      // one long stretch at full rate on both sides
      idle_on = (phase != 4);
      for (int i = 0; i < ((phase == 4) ? 60 : 25); i++)
        send_sample(pick_sample(), $urandom_range(7) == 0);
      wait_idle();
    end

    idle_on = 1'b1;
    send_sample(pick_sample(), 1'b1);
    wait_idle();
    drain_done <= 1'b1;
    repeat (3) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/egbp_pkg.sv
design/egbp_encoder.sv
design/egbp_drain.sv
design/exp_golomb_bit_packer_unit.sv
tb/egbp_stream_checker.sv
tb/tb_top.sv
